[sv/risc_instruction_decoder_defines.svh]
// assertion macros used by the instruction decoder top level
`ifndef RISC_INSTRUCTION_DECODER_DEFINES_SVH
`define RISC_INSTRUCTION_DECODER_DEFINES_SVH

// check that holds outside reset
`define RID_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that must also hold across reset
`define RID_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/rid_pkg.sv]
// types, opcode and function constants and lookup tables for the decoder
package rid_pkg;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00, OP_REGIMM = 6'h01, OP_J    = 6'h02,
                         OP_JAL     = 6'h03, OP_BEQ    = 6'h04, OP_BNE  = 6'h05,
                         OP_BLEZ    = 6'h06, OP_BGTZ   = 6'h07, OP_ADDI = 6'h08,
                         OP_ADDIU   = 6'h09, OP_SLTI   = 6'h0A, OP_SLTIU = 6'h0B,
                         OP_ANDI    = 6'h0C, OP_ORI    = 6'h0D, OP_XORI = 6'h0E,
                         OP_LUI     = 6'h0F, OP_LB     = 6'h20, OP_LH   = 6'h21,
                         OP_LWL     = 6'h22, OP_LW     = 6'h23, OP_LBU  = 6'h24,
                         OP_LHU     = 6'h25, OP_LWR    = 6'h26, OP_SB   = 6'h28,
                         OP_SH      = 6'h29, OP_SW     = 6'h2B;

  // function codes of the special opcode
  localparam logic [5:0] FN_SLL  = 6'h00, FN_SRL   = 6'h02, FN_SRA   = 6'h03,
                         FN_SLLV = 6'h04, FN_SRLV  = 6'h06, FN_SRAV  = 6'h07,
                         FN_JR   = 6'h08, FN_JALR  = 6'h09, FN_MFHI  = 6'h10,
                         FN_MTHI = 6'h11, FN_MFLO  = 6'h12, FN_MTLO  = 6'h13,
                         FN_MULT = 6'h18, FN_MULTU = 6'h19, FN_DIV   = 6'h1A,
                         FN_DIVU = 6'h1B, FN_ADD   = 6'h20, FN_ADDU  = 6'h21,
                         FN_SUB  = 6'h22, FN_SUBU  = 6'h23, FN_AND   = 6'h24,
                         FN_OR   = 6'h25, FN_XOR   = 6'h26, FN_SLT   = 6'h2A,
                         FN_SLTU = 6'h2B;

  // rt selectors of the regimm opcode
  localparam logic [4:0] RI_BLTZ = 5'h00, RI_BGEZ = 5'h01, RI_BLTZAL = 5'h10,
                         RI_BGEZAL = 5'h11;

  // instruction type codes
  typedef enum logic [5:0] {
    IT_ADD    = 6'd0,  IT_ADDI  = 6'd1,  IT_ADDIU = 6'd2,  IT_ADDU  = 6'd3,
    IT_AND    = 6'd4,  IT_ANDI  = 6'd5,  IT_BEQ   = 6'd6,  IT_BGEZ  = 6'd7,
    IT_BGEZAL = 6'd8,  IT_BGTZ  = 6'd9,  IT_BLEZ  = 6'd10, IT_BLTZ  = 6'd11,
    IT_BLTZAL = 6'd12, IT_BNE   = 6'd13, IT_DIV   = 6'd14, IT_DIVU  = 6'd15,
    IT_J      = 6'd16, IT_JALR  = 6'd17, IT_JAL   = 6'd18, IT_JR    = 6'd19,
    IT_LB     = 6'd20, IT_LBU   = 6'd21, IT_LH    = 6'd22, IT_LHU   = 6'd23,
    IT_LUI    = 6'd24, IT_LW    = 6'd25, IT_LWL   = 6'd26, IT_LWR   = 6'd27,
    IT_MFHI   = 6'd28, IT_MFLO  = 6'd29, IT_MTHI  = 6'd30, IT_MTLO  = 6'd31,
    IT_MULT   = 6'd32, IT_MULTU = 6'd33, IT_OR    = 6'd34, IT_ORI   = 6'd35,
    IT_SB     = 6'd36, IT_SH    = 6'd37, IT_SLL   = 6'd38, IT_SLLV  = 6'd39,
    IT_SLT    = 6'd40, IT_SLTI  = 6'd41, IT_SLTIU = 6'd42, IT_SLTU  = 6'd43,
    IT_SRA    = 6'd44, IT_SRAV  = 6'd45, IT_SRL   = 6'd46, IT_SRLV  = 6'd47,
    IT_SUB    = 6'd48, IT_SUBU  = 6'd49, IT_SW    = 6'd50, IT_XOR   = 6'd51,
    IT_XORI   = 6'd52
  } itype_t;

  // result of one table lookup
  typedef struct packed {
    logic   hit;
    itype_t code;
  } lookup_t;

  // one decoded word
  typedef struct packed {
    logic [5:0]         op;
    logic [4:0]         rs;
    logic [4:0]         rt;
    logic [4:0]         rd;
    logic [4:0]         shamt;
    logic [5:0]         funct;
    logic signed [15:0] imm;
    logic [25:0]        target;
    itype_t             itype;
    logic               invalid;
  } decoded_t;

  // function code table
  function automatic lookup_t funct_lookup(input logic [5:0] fn);
    lookup_t r;
    r = '{hit: 1'b1, code: IT_ADD};
    unique case (fn)
      FN_ADD:   r.code = IT_ADD;
      FN_ADDU:  r.code = IT_ADDU;
      FN_AND:   r.code = IT_AND;
      FN_DIV:   r.code = IT_DIV;
      FN_DIVU:  r.code = IT_DIVU;
      FN_JALR:  r.code = IT_JALR;
      FN_JR:    r.code = IT_JR;
      FN_MFHI:  r.code = IT_MFHI;
      FN_MFLO:  r.code = IT_MFLO;
      FN_MTHI:  r.code = IT_MTHI;
      FN_MTLO:  r.code = IT_MTLO;
      FN_MULT:  r.code = IT_MULT;
      FN_MULTU: r.code = IT_MULTU;
      FN_OR:    r.code = IT_OR;
      FN_SLL:   r.code = IT_SLL;
      FN_SLLV:  r.code = IT_SLLV;
      FN_SLT:   r.code = IT_SLT;
      FN_SLTU:  r.code = IT_SLTU;
      FN_SRA:   r.code = IT_SRA;
      FN_SRAV:  r.code = IT_SRAV;
      FN_SRL:   r.code = IT_SRL;
      FN_SRLV:  r.code = IT_SRLV;
      FN_SUB:   r.code = IT_SUB;
      FN_SUBU:  r.code = IT_SUBU;
      FN_XOR:   r.code = IT_XOR;
      default:  r.hit  = 1'b0;
    endcase
    return r;
  endfunction

  // primary opcode table for the immediate formats
  function automatic lookup_t opcode_lookup(input logic [5:0] op);
    lookup_t r;
    r = '{hit: 1'b1, code: IT_ADD};
    unique case (op)
      OP_ADDI:  r.code = IT_ADDI;
      OP_ADDIU: r.code = IT_ADDIU;
      OP_ANDI:  r.code = IT_ANDI;
      OP_BEQ:   r.code = IT_BEQ;
      OP_BGTZ:  r.code = IT_BGTZ;
      OP_BLEZ:  r.code = IT_BLEZ;
      OP_BNE:   r.code = IT_BNE;
      OP_LB:    r.code = IT_LB;
      OP_LBU:   r.code = IT_LBU;
      OP_LH:    r.code = IT_LH;
      OP_LHU:   r.code = IT_LHU;
      OP_LUI:   r.code = IT_LUI;
      OP_LW:    r.code = IT_LW;
      OP_LWL:   r.code = IT_LWL;
      OP_LWR:   r.code = IT_LWR;
      OP_ORI:   r.code = IT_ORI;
      OP_SB:    r.code = IT_SB;
      OP_SH:    r.code = IT_SH;
      OP_SLTI:  r.code = IT_SLTI;
      OP_SLTIU: r.code = IT_SLTIU;
      OP_SW:    r.code = IT_SW;
      OP_XORI:  r.code = IT_XORI;
      default:  r.hit  = 1'b0;
    endcase
    return r;
  endfunction

  // regimm branch table, selected by rt
  function automatic lookup_t regimm_lookup(input logic [4:0] rt);
    lookup_t r;
    r = '{hit: 1'b1, code: IT_ADD};
    unique case (rt)
      RI_BLTZ:   r.code = IT_BLTZ;
      RI_BGEZ:   r.code = IT_BGEZ;
      RI_BLTZAL: r.code = IT_BLTZAL;
      RI_BGEZAL: r.code = IT_BGEZAL;
      default:   r.hit  = 1'b0;
    endcase
    return r;
  endfunction

endpackage

[sv/risc_instruction_decoder.sv]
// top level of the instruction decoder: input register, decode, result register
// an accepted word is held in the input register, decoded, then loaded into the result register behind out_valid
// throughput: one word per cycle unless out_ready stalls, set by the single decode pass between registers
// a stalled result holds while a word may still enter the empty input register
// reset (rst, synchronous) empties both stages; payload registers are not reset
module risc_instruction_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        instr_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         op_field,
  output logic [4:0]         rs_index,
  output logic [4:0]         rt_index,
  output logic [4:0]         rd_index,
  output logic [4:0]         shift_amt,
  output logic [5:0]         funct_field,
  output logic signed [15:0] imm_value,
  output logic [25:0]        jump_target,
  output logic [5:0]         instr_type,
  output logic               invalid_flag
);
  import rid_pkg::*;

  `include "risc_instruction_decoder_defines.svh"

  logic        word_valid;
  logic [31:0] word;
  logic        res_valid;
  decoded_t    res;
  decoded_t    dec;
  logic        advance;

  // stage moves when the result register is free or being emptied
  assign advance  = !res_valid || out_ready;
  assign in_ready = !word_valid || advance;

  // input word register
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (in_ready) begin
      word_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      word <= instr_word;
    end
  end

  rid_decode u_decode (
    .instr_word (word),
    .dec        (dec)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= word_valid;
    end
    if (advance && word_valid) begin
      res <= dec;
    end
  end

  // output ports
  assign out_valid    = res_valid;
  assign op_field     = res.op;
  assign rs_index     = res.rs;
  assign rt_index     = res.rt;
  assign rd_index     = res.rd;
  assign shift_amt    = res.shamt;
  assign funct_field  = res.funct;
  assign imm_value    = res.imm;
  assign jump_target  = res.target;
  assign instr_type   = res.itype;
  assign invalid_flag = res.invalid;

  // checks
  `RID_ASSERT(a_invalid_code,
              res_valid && res.invalid |-> res.itype == IT_ADD,
              "invalid word with nonzero type")
  `RID_ASSERT(a_target_jump,
              res_valid && res.target != '0 |-> (res.op == OP_J || res.op == OP_JAL),
              "jump target on non-jump word")
  `RID_ASSERT(a_imm_itype,
              res_valid && res.imm != '0 |->
                (res.op != OP_SPECIAL && res.op != OP_J && res.op != OP_JAL),
              "immediate on R or J word")
  `RID_ASSERT(a_word_taken,
              in_valid && in_ready |=> word_valid,
              "accepted word lost from input stage")
  `RID_ASSERT_RST(a_reset_empty,
                  rst |=> !word_valid && !res_valid,
                  "stages not empty after reset")

endmodule

[sv/rid_decode.sv]
// combinational field split and type lookup for one instruction word
module rid_decode (
  input  logic [31:0]       instr_word,
  output rid_pkg::decoded_t dec
);
  import rid_pkg::*;

  logic [5:0] op;
  lookup_t    fn_hit;
  lookup_t    op_hit;
  lookup_t    ri_hit;

  assign op     = instr_word[31:26];
  assign fn_hit = funct_lookup(instr_word[5:0]);
  assign op_hit = opcode_lookup(op);
  assign ri_hit = regimm_lookup(instr_word[20:16]);

  // pick the format and clear unused fields
  always_comb begin
    dec         = '0;
    dec.op      = op;
    dec.itype   = IT_ADD;
    dec.invalid = 1'b1;
    priority if (op == OP_SPECIAL) begin
      dec.rs      = instr_word[25:21];
      dec.rt      = instr_word[20:16];
      dec.rd      = instr_word[15:11];
      dec.shamt   = instr_word[10:6];
      dec.funct   = instr_word[5:0];
      dec.itype   = fn_hit.code;
      dec.invalid = !fn_hit.hit;
    end else if (op == OP_J || op == OP_JAL) begin
      dec.target  = instr_word[25:0];
      dec.itype   = (op == OP_J) ? IT_J : IT_JAL;
      dec.invalid = 1'b0;
    end else if (op == OP_REGIMM) begin
      dec.rs      = instr_word[25:21];
      dec.rt      = instr_word[20:16];
      dec.imm     = instr_word[15:0];
      dec.itype   = ri_hit.code;
      dec.invalid = !ri_hit.hit;
    end else begin
      dec.rs      = instr_word[25:21];
      dec.rt      = instr_word[20:16];
      dec.imm     = instr_word[15:0];
      dec.itype   = op_hit.code;
      dec.invalid = !op_hit.hit;
    end
  end

endmodule
